// ===== rtl/serial_motor_command_decoder_top_assert.svh =====
// Assertion macros for the serial motor command decoder.
// Used by serial_motor_command_decoder_top; expects clk and arst_n in scope.
`ifndef SERIAL_MOTOR_COMMAND_DECODER_TOP_ASSERT_SVH
`define SERIAL_MOTOR_COMMAND_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SMCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/smcd_pkg.sv =====
// Shared types and constants for the serial motor command decoder.
// No dependencies.
package smcd_pkg;

	// Parser modes
	localparam logic [2:0] MODE_IDLE     = 3'd0;
	localparam logic [2:0] MODE_V_HUND   = 3'd1;
	localparam logic [2:0] MODE_V_TENS   = 3'd2;
	localparam logic [2:0] MODE_V_UNITS  = 3'd3;
	localparam logic [2:0] MODE_RAW      = 3'd4;
	localparam logic [2:0] MODE_B_FIRST  = 3'd5;
	localparam logic [2:0] MODE_B_SECOND = 3'd6;

	// Configuration register indexes
	localparam logic [2:0] REG_PRESET_ONE   = 3'd0;
	localparam logic [2:0] REG_PRESET_TWO   = 3'd1;
	localparam logic [2:0] REG_PRESET_THREE = 3'd2;
	localparam logic [2:0] REG_PRESET_FOUR  = 3'd3;
	localparam logic [2:0] REG_PRESET_FIVE  = 3'd4;
	localparam logic [2:0] REG_SPEED_STEP   = 3'd5;
	localparam logic [2:0] REG_DEC_FLOOR    = 3'd6;
	localparam logic [2:0] REG_INC_CEILING  = 3'd7;

	// Configuration reset values
	localparam logic [7:0] RST_PRESET_ONE   = 8'd170;
	localparam logic [7:0] RST_PRESET_TWO   = 8'd180;
	localparam logic [7:0] RST_PRESET_THREE = 8'd210;
	localparam logic [7:0] RST_PRESET_FOUR  = 8'd230;
	localparam logic [7:0] RST_PRESET_FIVE  = 8'hFF;
	localparam logic [7:0] RST_SPEED_STEP   = 8'd5;
	localparam logic [7:0] RST_DEC_FLOOR    = 8'd160;
	localparam logic [7:0] RST_INC_CEILING  = 8'd250;

	// Command and reply characters
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_3     = 8'h33;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_5     = 8'h35;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_V_LC  = 8'h76;
	localparam logic [7:0] CH_V_UC  = 8'h56;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_I_LC  = 8'h69;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_I_UC  = 8'h49;

	localparam logic [7:0] MUL_HUND = 8'd100;
	localparam logic [7:0] MUL_TENS = 8'd10;

	localparam int RESULT_W = 32;

	// Result item, packed lowest field in bit 0
	typedef struct packed {
		logic [2:0] pad;
		logic       awaiting_operand;
		logic       status_led;
		logic       direction_high;
		logic       direction_low;
		logic [7:0] duty_second;
		logic [7:0] duty_first;
		logic [7:0] reply_byte;
		logic       reply_valid;
	} result_t;

endpackage

// ===== rtl/serial_motor_command_decoder_top.sv =====
// Serial motor command decoder: top level.
// Depends on smcd_pkg and serial_motor_command_decoder_top_assert.svh.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one received byte per transaction.
//   m_tvalid/m_tready/m_tdata carry one result per input byte: reply flag and
//   character, both duty values, direction bits, LED bit and the flag that a
//   multi-byte command still expects operand bytes.
//   cfg_we/cfg_index/cfg_data write the presets, step, floor and ceiling;
//   write only while no byte is in flight.
// Timing:
//   A byte is held in an input register, decoded against the current command
//   state and written to the result register, where m_tvalid rises. One byte is
//   accepted every cycle while the receiver takes results; the rate is set by
//   the single decode stage between the two registers.
// Reset clears the parser to idle, speed, duties, direction and LED to zero,
// and loads the configuration defaults. When the receiver stalls, the result
// register holds, the input register fills, and s_tready drops after that.
module serial_motor_command_decoder_top
	import smcd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] rx_byte
	output logic                m_tvalid,
	input  logic                m_tready,
	// [0] reply_valid, [8:1] reply_byte, [16:9] duty_first, [24:17] duty_second,
	// [25] direction_low, [26] direction_high, [27] status_led,
	// [28] awaiting_operand, [31:29] zero
	output logic [RESULT_W-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	`include "serial_motor_command_decoder_top_assert.svh"

	// Configuration registers
	logic [7:0] preset_one_q, preset_two_q, preset_three_q, preset_four_q, preset_five_q;
	logic [7:0] speed_step_q, dec_floor_q, inc_ceiling_q;

	// Command state
	logic [2:0] mode_q, mode_d;
	logic [7:0] hund_q, hund_d, tens_q, tens_d;
	logic [7:0] speed_q, speed_d, duty1_q, duty1_d, duty2_q, duty2_d;
	logic       dir_lo_q, dir_lo_d, dir_hi_q, dir_hi_d, led_q, led_d;

	// Pipeline
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid_s2;
	result_t    res_s2;
	logic       adv;

	logic       reply_on, set_speed;
	logic [7:0] reply_chr, digit_val, dig_h, dig_t, dig_u;
	result_t    res_d;

	assign adv      = valid_s1 && (!res_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = res_valid_s2;
	assign m_tdata  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_one_q   <= RST_PRESET_ONE;
			preset_two_q   <= RST_PRESET_TWO;
			preset_three_q <= RST_PRESET_THREE;
			preset_four_q  <= RST_PRESET_FOUR;
			preset_five_q  <= RST_PRESET_FIVE;
			speed_step_q   <= RST_SPEED_STEP;
			dec_floor_q    <= RST_DEC_FLOOR;
			inc_ceiling_q  <= RST_INC_CEILING;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESET_ONE:   preset_one_q   <= cfg_data;
				REG_PRESET_TWO:   preset_two_q   <= cfg_data;
				REG_PRESET_THREE: preset_three_q <= cfg_data;
				REG_PRESET_FOUR:  preset_four_q  <= cfg_data;
				REG_PRESET_FIVE:  preset_five_q  <= cfg_data;
				REG_SPEED_STEP:   speed_step_q   <= cfg_data;
				REG_DEC_FLOOR:    dec_floor_q    <= cfg_data;
				REG_INC_CEILING:  inc_ceiling_q  <= cfg_data;
			endcase
		end
	end

	// Three-digit speed, modulo 256
	assign dig_h     = hund_q - CH_0;
	assign dig_t     = tens_q - CH_0;
	assign dig_u     = byte_s1 - CH_0;
	assign digit_val = 8'(dig_h * MUL_HUND) + 8'(dig_t * MUL_TENS) + dig_u;

	always_comb begin
		mode_d    = mode_q;
		hund_d    = hund_q;
		tens_d    = tens_q;
		speed_d   = speed_q;
		duty1_d   = duty1_q;
		duty2_d   = duty2_q;
		dir_lo_d  = dir_lo_q;
		dir_hi_d  = dir_hi_q;
		reply_on  = 1'b0;
		reply_chr = '0;
		set_speed = 1'b0;
		unique case (mode_q)
			MODE_V_HUND: begin
				hund_d = byte_s1;
				mode_d = MODE_V_TENS;
			end
			MODE_V_TENS: begin
				tens_d = byte_s1;
				mode_d = MODE_V_UNITS;
			end
			MODE_V_UNITS: begin
				speed_d   = digit_val;
				set_speed = 1'b1;
				reply_on  = 1'b1;
				reply_chr = CH_DOT;
				mode_d    = MODE_IDLE;
			end
			MODE_RAW: begin
				speed_d   = byte_s1;
				set_speed = 1'b1;
				reply_on  = 1'b1;
				reply_chr = CH_DOT;
				mode_d    = MODE_IDLE;
			end
			MODE_B_FIRST: begin
				duty1_d = byte_s1;
				mode_d  = MODE_B_SECOND;
			end
			MODE_B_SECOND: begin
				duty2_d   = byte_s1;
				reply_on  = 1'b1;
				reply_chr = CH_DOT;
				mode_d    = MODE_IDLE;
			end
			default: begin
				// idle, and the unused mode code
				mode_d = MODE_IDLE;
				unique case (byte_s1)
					CH_0: begin speed_d = '0;             set_speed = 1'b1; end
					CH_1: begin speed_d = preset_one_q;   set_speed = 1'b1; end
					CH_2: begin speed_d = preset_two_q;   set_speed = 1'b1; end
					CH_3: begin speed_d = preset_three_q; set_speed = 1'b1; end
					CH_4: begin speed_d = preset_four_q;  set_speed = 1'b1; end
					CH_5: begin speed_d = preset_five_q;  set_speed = 1'b1; end
					CH_MINUS: begin
						if (speed_q >= dec_floor_q) speed_d = speed_q - speed_step_q;
						set_speed = 1'b1;
					end
					CH_PLUS: begin
						if (speed_q <= inc_ceiling_q) speed_d = speed_q + speed_step_q;
						set_speed = 1'b1;
					end
					CH_Q: begin dir_lo_d = 1'b0; dir_hi_d = 1'b1; end
					CH_A: begin dir_lo_d = 1'b1; dir_hi_d = 1'b0; end
					CH_O: begin dir_lo_d = 1'b1; dir_hi_d = 1'b1; end
					CH_P: begin dir_lo_d = 1'b0; dir_hi_d = 1'b0; end
					CH_V_LC: mode_d = MODE_V_HUND;
					CH_V_UC: mode_d = MODE_RAW;
					CH_B:    mode_d = MODE_B_FIRST;
					CH_I_LC: begin reply_on = 1'b1; reply_chr = CH_I_UC; end
					default: begin speed_d = '0; set_speed = 1'b1; end
				endcase
			end
		endcase
		led_d = led_q;
		if (set_speed) begin
			duty1_d = speed_d;
			duty2_d = speed_d;
			led_d   = ~led_q;
		end
	end

	always_comb begin
		res_d                  = '0;
		res_d.reply_valid      = reply_on;
		res_d.reply_byte       = reply_chr;
		res_d.duty_first       = duty1_d;
		res_d.duty_second      = duty2_d;
		res_d.direction_low    = dir_lo_d;
		res_d.direction_high   = dir_hi_d;
		res_d.status_led       = led_d;
		res_d.awaiting_operand = (mode_d != MODE_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			speed_q      <= '0;
			duty1_q      <= '0;
			duty2_q      <= '0;
			dir_lo_q     <= 1'b0;
			dir_hi_q     <= 1'b0;
			led_q        <= 1'b0;
			valid_s1     <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv) begin
				mode_q       <= mode_d;
				speed_q      <= speed_d;
				duty1_q      <= duty1_d;
				duty2_q      <= duty2_d;
				dir_lo_q     <= dir_lo_d;
				dir_hi_q     <= dir_hi_d;
				led_q        <= led_d;
				res_valid_s2 <= 1'b1;
			end else if (m_tready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers: no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) byte_s1 <= s_tdata;
		if (adv) begin
			hund_q <= hund_d;
			tens_q <= tens_d;
			res_s2 <= res_d;
		end
	end

	`SMCD_ASSERT_NOW(a_reply_char, m_tvalid && m_tdata[0],
		(m_tdata[8:1] == CH_DOT) || (m_tdata[8:1] == CH_I_UC),
		"reply flagged with an unexpected character")
	`SMCD_ASSERT_NEXT(a_units_to_idle, adv && (mode_q == MODE_V_UNITS),
		mode_q == MODE_IDLE, "parser did not return to idle after last digit")
	`SMCD_ASSERT_NEXT(a_awaiting_flag, adv,
		m_tdata[28] == (mode_q != MODE_IDLE), "awaiting flag disagrees with parser mode")
	`SMCD_ASSERT_NEXT(a_led_toggle, adv && set_speed,
		led_q != $past(led_q), "LED did not toggle on speed command")

endmodule

// ===== tb/serial_motor_command_decoder_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the serial motor command decoder: decodes every accepted byte
// the way the block should and compares each result field by field.
// Depends on smcd_pkg; watches the stream and configuration ports only.
module serial_motor_command_decoder_checker
	import smcd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [RESULT_W-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output int                  fail_count,
	output int                  pending,
	output int                  checked
);

	logic [7:0] cfg_regs [8];

	logic [2:0] mode;
	logic [7:0] hundreds_byte;
	logic [7:0] tens_byte;
	logic [7:0] speed;
	logic [7:0] duty_one;
	logic [7:0] duty_two;
	logic       dir_zero;
	logic       dir_five;
	logic       led;

	result_t decoded_results [$];

	function automatic void take_speed();
		duty_one = speed;
		duty_two = speed;
		led = ~led;
	endfunction

	function automatic result_t decode_byte(input logic [7:0] b);
		result_t r;
		logic [7:0] h;
		logic [7:0] t;
		logic [7:0] u;
		r = '0;
		case (mode)
			MODE_V_HUND: begin
				hundreds_byte = b;
				mode = MODE_V_TENS;
			end
			MODE_V_TENS: begin
				tens_byte = b;
				mode = MODE_V_UNITS;
			end
			MODE_V_UNITS: begin
				// no digit check; the sum wraps at 8 bits
				h = hundreds_byte - CH_0;
				t = tens_byte - CH_0;
				u = b - CH_0;
				speed = h * MUL_HUND + t * MUL_TENS + u;
				take_speed();
				r.reply_valid = 1'b1;
				r.reply_byte = CH_DOT;
				mode = MODE_IDLE;
			end
			MODE_RAW: begin
				speed = b;
				take_speed();
				r.reply_valid = 1'b1;
				r.reply_byte = CH_DOT;
				mode = MODE_IDLE;
			end
			MODE_B_FIRST: begin
				duty_one = b;
				mode = MODE_B_SECOND;
			end
			MODE_B_SECOND: begin
				duty_two = b;
				r.reply_valid = 1'b1;
				r.reply_byte = CH_DOT;
				mode = MODE_IDLE;
			end
			default: begin
				mode = MODE_IDLE;
				case (b)
					CH_0: begin
						speed = '0;
						take_speed();
					end
					CH_1: begin
						speed = cfg_regs[REG_PRESET_ONE];
						take_speed();
					end
					CH_2: begin
						speed = cfg_regs[REG_PRESET_TWO];
						take_speed();
					end
					CH_3: begin
						speed = cfg_regs[REG_PRESET_THREE];
						take_speed();
					end
					CH_4: begin
						speed = cfg_regs[REG_PRESET_FOUR];
						take_speed();
					end
					CH_5: begin
						speed = cfg_regs[REG_PRESET_FIVE];
						take_speed();
					end
					CH_MINUS: begin
						if (speed >= cfg_regs[REG_DEC_FLOOR])
							speed = speed - cfg_regs[REG_SPEED_STEP];
						take_speed();
					end
					CH_PLUS: begin
						if (speed <= cfg_regs[REG_INC_CEILING])
							speed = speed + cfg_regs[REG_SPEED_STEP];
						take_speed();
					end
					CH_Q: begin
						dir_zero = 1'b0;
						dir_five = 1'b1;
					end
					CH_A: begin
						dir_zero = 1'b1;
						dir_five = 1'b0;
					end
					CH_O: begin
						dir_zero = 1'b1;
						dir_five = 1'b1;
					end
					CH_P: begin
						dir_zero = 1'b0;
						dir_five = 1'b0;
					end
					CH_V_LC: mode = MODE_V_HUND;
					CH_V_UC: mode = MODE_RAW;
					CH_B:    mode = MODE_B_FIRST;
					CH_I_LC: begin
						r.reply_valid = 1'b1;
						r.reply_byte = CH_I_UC;
					end
					default: begin
						speed = '0;
						take_speed();
					end
				endcase
			end
		endcase
		r.duty_first = duty_one;
		r.duty_second = duty_two;
		r.direction_low = dir_zero;
		r.direction_high = dir_five;
		r.status_led = led;
		r.awaiting_operand = (mode != MODE_IDLE);
		return r;
	endfunction

	task automatic check_result(input result_t got);
		result_t want;
		checked++;
		if (decoded_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result %h arrived with nothing outstanding", $realtime, got);
		end else begin
			want = decoded_results.pop_front();
			if (got.reply_valid !== want.reply_valid || got.reply_byte !== want.reply_byte ||
			    got.duty_first !== want.duty_first || got.duty_second !== want.duty_second ||
			    got.direction_low !== want.direction_low ||
			    got.direction_high !== want.direction_high ||
			    got.status_led !== want.status_led ||
			    got.awaiting_operand !== want.awaiting_operand || got.pad !== want.pad) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: mismatch  expected rv=%0d rb=%02h d1=%02h d2=%02h",
					         $realtime, want.reply_valid, want.reply_byte,
					         want.duty_first, want.duty_second);
					$display("    expected dl=%0d dh=%0d led=%0d wait=%0d pad=%0d",
					         want.direction_low, want.direction_high, want.status_led,
					         want.awaiting_operand, want.pad);
					$display("    got rv=%0d rb=%02h d1=%02h d2=%02h",
					         got.reply_valid, got.reply_byte, got.duty_first,
					         got.duty_second);
					$display("    got dl=%0d dh=%0d led=%0d wait=%0d pad=%0d",
					         got.direction_low, got.direction_high, got.status_led,
					         got.awaiting_operand, got.pad);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs[REG_PRESET_ONE] = RST_PRESET_ONE;
			cfg_regs[REG_PRESET_TWO] = RST_PRESET_TWO;
			cfg_regs[REG_PRESET_THREE] = RST_PRESET_THREE;
			cfg_regs[REG_PRESET_FOUR] = RST_PRESET_FOUR;
			cfg_regs[REG_PRESET_FIVE] = RST_PRESET_FIVE;
			cfg_regs[REG_SPEED_STEP] = RST_SPEED_STEP;
			cfg_regs[REG_DEC_FLOOR] = RST_DEC_FLOOR;
			cfg_regs[REG_INC_CEILING] = RST_INC_CEILING;
			mode = MODE_IDLE;
			hundreds_byte = '0;
			tens_byte = '0;
			speed = '0;
			duty_one = '0;
			duty_two = '0;
			dir_zero = 1'b0;
			dir_five = 1'b0;
			led = 1'b0;
			decoded_results.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (cfg_we)
				cfg_regs[cfg_index] = cfg_data;
			// a result is registered after its byte is accepted, so pop before push
			if (m_tvalid && m_tready)
				check_result(result_t'(m_tdata));
			if (s_tvalid && s_tready)
				decoded_results.push_back(decode_byte(s_tdata));
			pending = decoded_results.size();
		end
	end

endmodule

// ===== tb/serial_motor_command_decoder_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the serial motor command decoder: clock, reset, command
// byte stimulus, register phases and output back-pressure; verdict at the end.
// Depends on smcd_pkg, serial_motor_command_decoder_top and the checker module.
module serial_motor_command_decoder_top_tb;
	import smcd_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASES = 8;
	localparam int PHASE_BYTES = 68;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [RESULT_W-1:0] m_tdata;
	logic                cfg_we = 1'b0;
	logic [2:0]          cfg_index = '0;
	logic [7:0]          cfg_data = '0;

	int fail_count;
	int pending;
	int checked;
	int bytes_sent = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;

	always #4 clk = ~clk;

	serial_motor_command_decoder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	serial_motor_command_decoder_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending),
		.checked   (checked)
	);

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_served + 1;
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					m_tready <= 1'b0;
					@(posedge clk);
				end
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Watchdog: end the run after too many cycles without any transaction.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// Hold the input idle until every result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// kind 0: reset defaults, 1: all zero, 2: all ones, otherwise random
	task automatic program_regs(input int kind);
		logic [7:0] value;
		for (int i = REG_PRESET_ONE; i <= REG_INC_CEILING; i++) begin
			case (kind)
				0: begin
					case (i)
						REG_PRESET_ONE:   value = RST_PRESET_ONE;
						REG_PRESET_TWO:   value = RST_PRESET_TWO;
						REG_PRESET_THREE: value = RST_PRESET_THREE;
						REG_PRESET_FOUR:  value = RST_PRESET_FOUR;
						REG_PRESET_FIVE:  value = RST_PRESET_FIVE;
						REG_SPEED_STEP:   value = RST_SPEED_STEP;
						REG_DEC_FLOOR:    value = RST_DEC_FLOOR;
						default:          value = RST_INC_CEILING;
					endcase
				end
				1:       value = 8'h00;
				2:       value = 8'hFF;
				default: value = 8'($urandom_range(255));
			endcase
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= value;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// One command, mostly well formed, with any byte as operand.
	task automatic send_command();
		int pick;
		pick = $urandom_range(99);
		if (pick < 14) begin
			send_byte(CH_0 + 8'($urandom_range(5)));
		end else if (pick < 30) begin
			send_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
		end else if (pick < 40) begin
			case ($urandom_range(3))
				0:       send_byte(CH_Q);
				1:       send_byte(CH_A);
				2:       send_byte(CH_O);
				default: send_byte(CH_P);
			endcase
		end else if (pick < 45) begin
			send_byte(CH_I_LC);
		end else if (pick < 62) begin
			send_byte(CH_V_LC);
			repeat (3) begin
				if ($urandom_range(99) < 80)
					send_byte(CH_0 + 8'($urandom_range(9)));
				else
					send_byte(8'($urandom_range(255)));
			end
		end else if (pick < 72) begin
			send_byte(CH_V_UC);
			send_byte(8'($urandom_range(255)));
		end else if (pick < 84) begin
			send_byte(CH_B);
			send_byte(8'($urandom_range(255)));
			send_byte(8'($urandom_range(255)));
		end else begin
			send_byte(8'($urandom_range(255)));
		end
	endtask

	initial begin : stimulus
		int phase_start;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: presets, step limits, directions, ping, operand commands,
		// command letters taken as operands, extreme and unknown bytes
		send_byte(CH_1);
		send_byte(CH_PLUS);
		send_byte(CH_MINUS);
		send_byte(CH_5);
		send_byte(CH_PLUS);
		send_byte(CH_0);
		send_byte(CH_MINUS);
		send_byte(CH_Q);
		send_byte(CH_A);
		send_byte(CH_O);
		send_byte(CH_P);
		send_byte(CH_I_LC);
		send_byte(CH_V_LC);
		send_byte(CH_2);
		send_byte(CH_5);
		send_byte(CH_5);
		send_byte(CH_V_LC);
		send_byte(CH_0 + 8'd9);
		send_byte(CH_0 + 8'd9);
		send_byte(CH_0 + 8'd9);
		send_byte(CH_V_UC);
		send_byte(CH_V_LC);
		send_byte(CH_B);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			program_regs(phase < 3 ? phase : 3);
			case (phase % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 76;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 76;
				end
				default: begin
					src_idle_pct = 38;
					sink_stall_pct = 38;
				end
			endcase
			// long output hold while the input keeps offering bytes
			if (phase == 4)
				hold_requests = hold_requests + 1;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES)
				send_command();
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d command bytes and checked %0d results over %0d register sets,",
		         bytes_sent, checked, PHASES + 1);
		$display("with free-running, idle-input, stalled-output and mixed flow plus one long hold.");
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/smcd_pkg.sv
rtl/serial_motor_command_decoder_top.sv
tb/serial_motor_command_decoder_checker.sv
tb/serial_motor_command_decoder_top_tb.sv
